### design/tal_pkg.sv
// tal_pkg: shared constants, codes, state type and control structs of the
// tag allow-list table. No dependencies.
`timescale 1ns / 1ps

package tal_pkg;

   localparam int MAX_TAGS_DEFAULT = 16;
   localparam int TAG_BYTES        = 12;
   localparam int TAG_W            = TAG_BYTES * 8;

   // request codes (code 3 behaves as a lookup)
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       clr_scan;
      logic       inc_idx;
      logic       rd_search;
      logic       rd_shift;
      logic       wr_append;
      logic       wr_shift;
      logic       set_hit;
      logic       dec_count;
      logic       load_rsp;
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       idx_lt_count;
      logic       nxt_lt_count;
      logic       tag_eq;
      logic       full;
      logic       rsp_busy;
   } sts_type;

endpackage

### design/tag_allow_list_table_top.sv
// tag_allow_list_table_top: ordered set of up to MAX_TAGS 96-bit tags.
// Depends on tal_pkg, tal_controller and tal_datapath.
`timescale 1ns / 1ps

// usage
//   req channel: one beat is a request (req_type 0 lookup, 1 add, 2 remove,
//   3 acts as lookup) with the tag split into req_tag_high / req_tag_low
//   rsp channel: one beat per request with status, match index and the
//   entry count after the request
// timing
//   one request at a time; req_ready is high only while the sequencer idles
//   scan walks the stored entries, one read and one compare per entry, through the
//   single read port of the tag memory
//   remove then compacts the table, a read and a write per later entry
//   req_ready rises with rsp_valid
// reset
//   synchronous; clears the entry count and the sequencer, tag memory is not
//   cleared since only entries below the count are ever read
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and the next result holds in the sequencer until rsp_ready

module tag_allow_list_table_top
   import tal_pkg::*;
#(
   parameter int MAX_TAGS = MAX_TAGS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_tag_high,
   input  logic [63:0] req_tag_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_match_index,
   output logic [4:0]  rsp_entry_count
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: scan, append and compaction steps
   tal_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tag memory, count, scan index and result register
   tal_datapath #(
      .MAX_TAGS (MAX_TAGS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_tag_high    (req_tag_high),
      .req_tag_low     (req_tag_low),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

### design/tal_datapath.sv
// tal_datapath: tag memory, request and response registers, scan index and
// entry count. Depends on tal_pkg; driven by tal_controller commands.
`timescale 1ns / 1ps

module tal_datapath
   import tal_pkg::*;
#(
   parameter int MAX_TAGS = MAX_TAGS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_type,
   input  logic [31:0]       req_tag_high,
   input  logic [63:0]       req_tag_low,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_match_index,
   output logic [4:0]        rsp_entry_count
);

   localparam int IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int CNT_W = $clog2(MAX_TAGS + 1);

   logic [TAG_W-1:0] mem [MAX_TAGS];

   logic [1:0]       req_type_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [CNT_W-1:0] idx_ff,   idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             hit_ff,   hit_in;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [TAG_W-1:0] rdata_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [3:0]       rsp_index_ff;
   logic [4:0]       rsp_count_ff;

   logic [CNT_W-1:0] nxt_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [TAG_W-1:0] wr_data;
   logic             wr_en;

   assign nxt_idx = idx_ff + CNT_W'(1);
   assign rd_addr = cmd.rd_shift ? nxt_idx[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_addr = cmd.wr_append ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_append ? tag_ff : rdata_ff;
   assign wr_en   = cmd.wr_append | cmd.wr_shift;

   // tag memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_search | cmd.rd_shift) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_scan) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = nxt_idx;
      end
      count_in = count_ff;
      if (cmd.wr_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      hit_in = hit_ff;
      if (cmd.clr_scan) begin
         hit_in = 1'b0;
      end else if (cmd.set_hit) begin
         hit_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         tag_ff      <= {req_tag_high, req_tag_low};
      end
      if (cmd.set_hit) begin
         hit_idx_ff <= idx_ff[IDX_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_index_ff  <= hit_ff ? 4'(hit_idx_ff) : 4'd0;
         rsp_count_ff  <= 5'(count_ff);
      end
   end

   always_comb begin
      sts.req_type     = req_type_ff;
      sts.idx_lt_count = idx_ff < count_ff;
      sts.nxt_lt_count = nxt_idx < count_ff;
      sts.tag_eq       = rdata_ff == tag_ff;
      sts.full         = count_ff >= CNT_W'(MAX_TAGS);
      sts.rsp_busy     = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### design/tal_controller.sv
// tal_controller: request sequencer (scan, append, compaction shift).
// Depends on tal_pkg; steers tal_datapath through cmd_type / sts_type.
`timescale 1ns / 1ps

module tal_controller
   import tal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (sts.idx_lt_count) begin
               cmd.rd_search = 1'b1;
               state_in      = S_SCAN_CMP;
            end else begin
               // no match in the table
               state_in = S_FINISH;
               if (sts.req_type == REQ_ADD) begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.wr_append = 1'b1;
                     status_in     = ST_OK;
                  end
               end else begin
                  status_in = ST_MISSING;
               end
            end
         end
         S_SCAN_CMP: begin
            if (sts.tag_eq) begin
               cmd.set_hit = 1'b1;
               if (sts.req_type == REQ_ADD) begin
                  status_in = ST_PRESENT;
                  state_in  = S_FINISH;
               end else if (sts.req_type == REQ_REMOVE) begin
                  status_in = ST_OK;
                  state_in  = S_SHIFT_RD;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_FINISH;
               end
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (sts.nxt_lt_count) begin
               cmd.rd_shift = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.dec_count = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### tb/tb_tag_allow_list_table_top.sv
// tb_tag_allow_list_table_top: self-checking bench for the tag allow-list table,
// with directed and random request traffic and a scoreboard fed by a table predictor.
// Depends on tal_pkg and tag_allow_list_table_top.
`timescale 1ns / 1ps

module tb_tag_allow_list_table_top;
   import tal_pkg::*;

   localparam int TABLE_DEPTH   = MAX_TAGS_DEFAULT;
   localparam int POOL_SIZE     = 24;
   // bound on the whole run; each request adds its scan and shift walk, a random gap and a random stall
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 80;
   // request code 3 is not named in the package; the block treats it as a lookup
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] match_index;
      logic [4:0] entry_count;
   } table_outcome_type;

   // clock, reset and block ports; every input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_LOOKUP;
   logic [31:0] req_tag_high = '0;
   logic [63:0] req_tag_low = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_match_index;
   logic [4:0]  rsp_entry_count;

   // predictor copy of the table
   logic [95:0] allow_tags [TABLE_DEPTH];
   int          allow_count = 0;

   // outcomes still owed by the block, oldest first
   table_outcome_type pending_results [$];

   // random tag pool, so that adds, lookups and removes hit stored entries
   logic [95:0] tag_pool [POOL_SIZE];

   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          rsp_hold = 0;
   // no gaps and no stalls while set
   bit          quiet_mode = 1'b0;

   always #6 clock = ~clock;

   tag_allow_list_table_top #(
      .MAX_TAGS (TABLE_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_tag_high    (req_tag_high),
      .req_tag_low     (req_tag_low),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_entry_count (rsp_entry_count)
   );

   // applies one request to the predictor table and returns the outcome
   function automatic table_outcome_type apply_table_request(input logic [1:0] kind,
                                                              input logic [95:0] tag);
      table_outcome_type res;
      int hit;
      int i;
      hit = -1;
      // first match among stored entries only
      for (i = 0; i < allow_count; i++) begin
         if (hit < 0 && allow_tags[i] == tag) begin
            hit = i;
         end
      end
      res.status      = ST_MISSING;
      res.match_index = '0;
      case (kind)
         REQ_ADD: begin
            if (hit >= 0) begin
               // duplicate wins over full
               res.status      = ST_PRESENT;
               res.match_index = 4'(hit);
            end else if (allow_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               allow_tags[allow_count] = tag;
               allow_count++;
               res.status = ST_OK;
            end
         end
         REQ_REMOVE: begin
            if (hit >= 0) begin
               // compact: later entries move down one place, order kept
               for (i = hit; i + 1 < allow_count; i++) begin
                  allow_tags[i] = allow_tags[i + 1];
               end
               allow_count--;
               res.status      = ST_OK;
               res.match_index = 4'(hit);
            end
         end
         default: begin
            // lookup, and the spare code acting as one
            if (hit >= 0) begin
               res.status      = ST_OK;
               res.match_index = 4'(hit);
            end
         end
      endcase
      res.entry_count = 5'(allow_count);
      return res;
   endfunction

   // sends one request beat; returns at the edge where it was accepted,
   // with valid still high so a back-to-back beat needs no extra edge
   task automatic send_request(input logic [1:0] kind, input logic [95:0] tag);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_tag_high <= tag[95:64];
      req_tag_low  <= tag[63:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_table_request(kind, tag));
   endtask

   // drops valid and holds off until every owed result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // fresh pool; some entries differ from their neighbor in a single bit
   task automatic refresh_tag_pool();
      int i;
      for (i = 0; i < POOL_SIZE; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0) begin
            tag_pool[i] = tag_pool[i - 1] ^ (96'd1 << $urandom_range(0, 95));
         end else begin
            tag_pool[i] = {$urandom, $urandom, $urandom};
         end
      end
   endtask

   // lookup, remove and the spare code on an empty table
   task automatic test_empty_table();
      send_request(REQ_LOOKUP, '0);
      send_request(REQ_REMOVE, '1);
      send_request(REQ_SPARE, {32'h1, 64'h0});
   endtask

   // fill to capacity with extreme tags, then full, duplicate and edge removes
   task automatic test_fill_to_capacity();
      logic [95:0] fill_tags [TABLE_DEPTH];
      int i;
      fill_tags[0] = '0;
      fill_tags[1] = '1;
      fill_tags[2] = {32'hFFFF_FFFF, 64'h0};
      fill_tags[3] = {32'h0, 64'hFFFF_FFFF_FFFF_FFFF};
      for (i = 4; i < TABLE_DEPTH; i++) begin
         fill_tags[i] = {$urandom, $urandom, $urandom};
      end
      for (i = 0; i < TABLE_DEPTH; i++) begin
         send_request(REQ_ADD, fill_tags[i]);
      end
      send_request(REQ_ADD, fill_tags[1]);                 // duplicate while full
      send_request(REQ_ADD, {32'h0, 64'h1});               // new tag while full
      send_request(REQ_LOOKUP, fill_tags[TABLE_DEPTH - 1]); // last slot
      send_request(REQ_SPARE, fill_tags[3]);
      send_request(REQ_REMOVE, fill_tags[0]);              // longest shift walk
      send_request(REQ_REMOVE, fill_tags[TABLE_DEPTH - 1]); // now the last entry
      send_request(REQ_LOOKUP, fill_tags[1] ^ (96'd1 << 95)); // one bit off
   endtask

   // random traffic over the pool, with a share of fresh tags as noise
   task automatic test_random_traffic(input int count, input int add_pct,
                                      input int remove_pct);
      int n;
      int pick;
      logic [1:0] kind;
      logic [95:0] tag;
      refresh_tag_pool();
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < add_pct) begin
            kind = REQ_ADD;
         end else if (pick < add_pct + remove_pct) begin
            kind = REQ_REMOVE;
         end else if ($urandom_range(0, 7) == 0) begin
            kind = REQ_SPARE;
         end else begin
            kind = REQ_LOOKUP;
         end
         if ($urandom_range(0, 99) < 85) begin
            tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            tag = {$urandom, $urandom, $urandom};
         end
         send_request(kind, tag);
      end
   endtask

   // scoreboard: each result beat against the oldest owed outcome
   always @(posedge clock) begin
      table_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_hold = quiet_mode ? 0 : $urandom_range(0, 10);
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none owed: status %0d index %0d count %0d",
                     $time, rsp_status, rsp_match_index, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_match_index !== want.match_index) begin
               $display("%0t: match_index expected %0d actual %0d",
                        $time, want.match_index, rsp_match_index);
               mismatch_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   end

   // result side: stall drawn per beat, counted down on falling edges
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_tag_allow_list_table_top failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      test_empty_table();
      test_fill_to_capacity();

      // random part, alternating gappy and back-to-back stretches
      test_random_traffic(150, 60, 15);
      quiet_mode = 1'b1;
      test_random_traffic(150, 15, 60);
      // full hold-off until the block has answered everything
      wait_for_results();
      quiet_mode = 1'b0;
      test_random_traffic(200, 35, 35);
      quiet_mode = 1'b1;
      test_random_traffic(150, 65, 10);
      quiet_mode = 1'b0;
      test_random_traffic(150, 10, 65);
      test_random_traffic(125, 40, 30);

      // drain, then watch for stray beats
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_tag_allow_list_table_top passed");
      end else begin
         $display("tb_tag_allow_list_table_top failed");
      end
      $finish;
   end

endmodule

### sim.f
design/tal_pkg.sv
design/tal_datapath.sv
design/tal_controller.sv
design/tag_allow_list_table_top.sv
tb/tb_tag_allow_list_table_top.sv
